FILE: hw/rtl/csdr_pkg.sv
// Shared types, codes and constants of the complex sample detector.
// Depends on nothing; the root unit, the detector and its testbench import it.
package csdr_pkg;

   // register indexes
   localparam logic [2:0] REG_FORMAT = 3'd0;
   localparam logic [2:0] REG_MODE   = 3'd1;
   localparam logic [2:0] REG_AUTO   = 3'd2;
   localparam logic [2:0] REG_CLIPLO = 3'd3;
   localparam logic [2:0] REG_CLIPHI = 3'd4;
   localparam logic [2:0] REG_FLOOR  = 3'd5;

   // sample formats
   localparam logic [1:0] FMT_CPLX = 2'd0;
   localparam logic [1:0] FMT_REAL = 2'd1;
   localparam logic [1:0] FMT_INT  = 2'd2;

   // output modes
   localparam logic [2:0] MODE_MOD   = 3'd0;
   localparam logic [2:0] MODE_DB10  = 3'd1;
   localparam logic [2:0] MODE_DB20  = 3'd2;
   localparam logic [2:0] MODE_PHASE = 3'd3;
   localparam logic [2:0] MODE_IM    = 3'd5;

   localparam int CORDIC_STEPS_DEF = 20;

   localparam logic [63:0]        PI_Q60   = 64'h3243F6A8885A308D;
   localparam logic signed [52:0] PI_Q48   = 53'(PI_Q60 >> 12);
   localparam logic [33:0]        PI_Q32   = 34'(PI_Q60 >> 28);
   localparam logic signed [31:0] DEG180   = 32'sd11796480;
   localparam logic signed [32:0] K_DB10   = 33'sd197283;
   localparam logic signed [32:0] K_DB20   = 33'sd394566;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_SQ_RE, S_SQ_IM, S_SQ_ADD, S_SQRT_GO, S_SQRT_WAIT,
      S_LOG_FLOOR, S_LOG_NORM, S_LOG_MUL, S_LOG_STEP, S_LOG_FRK, S_LOG_EK,
      S_LOG_SUM, S_PH_INIT, S_PH_ITER, S_PH_SCALE, S_PH_DIV, S_PH_CLAMP,
      S_TRUNC, S_RANGE
   } csdr_state_type;

   // restoring long division, used only while building constant tables
   function automatic logic [63:0] const_udiv(input logic [63:0] num,
                                             input logic [63:0] dvs);
      logic [63:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= dvs) begin
            rem    = rem - dvs;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // atan(2^-i) in Q48 radians from its power series in Q62
   function automatic logic signed [63:0] atan_q48(input int unsigned i);
      logic signed [63:0] s;
      logic [63:0]        t;
      int unsigned        n;
      int unsigned        pw;
      s = '0;
      if (i == 0) begin
         return 64'(PI_Q60 >> 14);
      end
      for (int unsigned k = 0; k < 32; k++) begin
         n  = 2 * k + 1;
         pw = i * n;
         if (pw <= 62) begin
            t = const_udiv(64'd1 << (62 - pw), 64'(n));
            if (k[0]) s = s - signed'(t);
            else      s = s + signed'(t);
         end
      end
      return (s + 64'sd8192) >>> 14;
   endfunction

endpackage

FILE: hw/rtl/csdr_if.sv
// Handshake channels of the detector: sample input, result output, register writes.
// Depends on nothing.
interface csdr_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sample_re;
   logic signed [31:0] sample_im;
   logic               last_in;
   modport source (output valid, sample_re, sample_im, last_in, input ready);
   modport sink   (input valid, sample_re, sample_im, last_in, output ready);
endinterface

interface csdr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;
   logic signed [31:0] range_min;
   logic signed [31:0] range_max;
   logic               last_out;
   modport source (output valid, value, range_min, range_max, last_out, input ready);
   modport sink   (input valid, value, range_min, range_max, last_out, output ready);
endinterface

interface csdr_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/csdr_isqrt.sv
// Bit-serial integer square root: one root bit per cycle.
// Depends on csdr_pkg only for the house import.
module csdr_isqrt
   import csdr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] operand,
   output logic        done,
   output logic [31:0] root
);

   logic [63:0] opnd_ff, opnd_in;
   logic [35:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [35:0] rem_sh;
   logic [35:0] trial;

   // one radix-4 digit of the operand per cycle
   always_comb begin
      rem_sh  = {rem_ff[33:0], opnd_ff[63:62]};
      trial   = {2'b00, root_ff, 2'b01};
      opnd_in = opnd_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         opnd_in = operand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         opnd_in = {opnd_ff[61:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      opnd_ff <= opnd_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

FILE: hw/rtl/complex_sample_detect_and_range.sv
// Steps from the input transfer to result valid: pass-through modes go through
// dispatch, truncation and range; modulus adds the squares and the root unit;
// decibels add the root (complex samples), normalize shifts and one squaring per
// fraction bit; phase adds CORDIC iterations, then a bit-serial degree divider.
// One sample at a time on a shared 33x33 multiplier; the next sample is taken the
// cycle after the result is loaded into the output register.
// Synchronous reset restores register defaults and restarts the running range.
module complex_sample_detect_and_range
   import csdr_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)(
   input  logic  clock,
   input  logic  reset,
   csdr_req_if.sink   req_chan,
   csdr_rsp_if.source rsp_chan,
   csdr_csr_if.sink   csr_chan
);

   localparam int CNT_W = $clog2(CORDIC_STEPS);

   csdr_state_type state_ff, state_in;

   // configuration
   logic [1:0]         fmt_ff;
   logic [2:0]         mode_ff;
   logic               auto_ff;
   logic signed [31:0] clip_lo_ff, clip_hi_ff;
   logic [16:0]        floor_ff;

   // working registers
   logic signed [31:0] re_ff, re_in, im_ff, im_in;
   logic               last_ff, last_in_w;
   logic signed [65:0] prod_ff;
   logic [63:0]        sq_ff, sq_in;
   logic [31:0]        mag_ff, mag_in;
   logic [4:0]         exp_ff, exp_in;
   logic [31:0]        fr_ff, fr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic signed [35:0] x_ff, x_in, y_ff, y_in;
   logic signed [52:0] z_ff, z_in;
   logic [59:0]        rem_ff, rem_in, dvs_ff, dvs_in;
   logic [25:0]        quot_ff, quot_in;
   logic [4:0]         dcnt_ff, dcnt_in;
   logic               neg_ff, neg_in;
   logic signed [31:0] acc_ff, acc_in;
   logic signed [31:0] v_ff, v_in;

   // range state and output register
   logic signed [31:0] run_min_ff, run_min_in, run_max_ff, run_max_in;
   logic               first_ff, first_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic signed [31:0] rsp_min_ff, rsp_min_in, rsp_max_ff, rsp_max_in;
   logic               rsp_last_ff, rsp_last_in;

   // FSM outputs
   logic               req_take;
   logic               sqrt_start;
   logic               out_free;
   logic signed [32:0] mul_a, mul_b;

   logic               sqrt_done;
   logic [31:0]        sqrt_root;

   logic signed [52:0] atan_tab [CORDIC_STEPS];

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_atan
      assign atan_tab[g] = 53'(atan_q48(g));
   end

   csdr_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .operand (sq_ff),
      .done    (sqrt_done),
      .root    (sqrt_root)
   );

   // configuration writes
   assign csr_chan.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff     <= FMT_CPLX;
         mode_ff    <= MODE_MOD;
         auto_ff    <= 1'b1;
         clip_lo_ff <= 32'sh8000_0000;
         clip_hi_ff <= 32'sh7FFF_FFFF;
         floor_ff   <= 17'd1;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_FORMAT: fmt_ff     <= csr_chan.data[1:0];
            REG_MODE:   mode_ff    <= csr_chan.data[2:0];
            REG_AUTO:   auto_ff    <= csr_chan.data[0];
            REG_CLIPLO: clip_lo_ff <= signed'(csr_chan.data);
            REG_CLIPHI: clip_hi_ff <= signed'(csr_chan.data);
            REG_FLOOR:  floor_ff   <= csr_chan.data[16:0];
            default: ;
         endcase
      end
   end

   logic is_cplx_mag;
   logic is_real_fmt;
   logic db_mode;
   logic sat_hit;
   logic [32:0] abs_re;
   logic signed [31:0] trunc_v;
   logic ph_fixed;

   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign db_mode     = (mode_ff == MODE_DB10) || (mode_ff == MODE_DB20);
   assign is_cplx_mag = (fmt_ff == FMT_CPLX) && ((mode_ff == MODE_MOD) || db_mode);
   assign is_real_fmt = (fmt_ff == FMT_REAL) || (fmt_ff == FMT_INT);
   assign abs_re      = re_ff[31] ? 33'(-(34'(re_ff))) : 33'(re_ff);
   assign sat_hit     = abs_re[31];
   assign ph_fixed    = (fmt_ff != FMT_INT) && (mode_ff == MODE_PHASE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:      if (req_chan.valid) state_in = S_DISPATCH;
         S_DISPATCH: begin
            if (is_cplx_mag)                                        state_in = S_SQ_RE;
            else if ((fmt_ff == FMT_CPLX) && (mode_ff == MODE_PHASE)) state_in = S_PH_INIT;
            else if (is_real_fmt && db_mode)                        state_in = S_LOG_FLOOR;
            else                                                    state_in = S_TRUNC;
         end
         S_SQ_RE:     state_in = S_SQ_IM;
         S_SQ_IM:     state_in = S_SQ_ADD;
         S_SQ_ADD:    state_in = S_SQRT_GO;
         S_SQRT_GO:   state_in = S_SQRT_WAIT;
         S_SQRT_WAIT: if (sqrt_done) state_in = db_mode ? S_LOG_FLOOR : S_TRUNC;
         S_LOG_FLOOR: state_in = S_LOG_NORM;
         S_LOG_NORM:  if (mag_ff[31]) state_in = S_LOG_MUL;
         S_LOG_MUL:   state_in = S_LOG_STEP;
         S_LOG_STEP:  state_in = (cnt_ff == CNT_W'(CORDIC_STEPS - 1)) ? S_LOG_FRK : S_LOG_MUL;
         S_LOG_FRK:   state_in = S_LOG_EK;
         S_LOG_EK:    state_in = S_LOG_SUM;
         S_LOG_SUM:   state_in = S_TRUNC;
         S_PH_INIT:   state_in = ((re_ff == 0) && (im_ff == 0)) ? S_TRUNC : S_PH_ITER;
         S_PH_ITER: begin
            if ((y_ff == 0) || (cnt_ff == CNT_W'(CORDIC_STEPS - 1))) state_in = S_PH_SCALE;
         end
         S_PH_SCALE:  state_in = S_PH_DIV;
         S_PH_DIV:    if (dcnt_ff == 5'd0) state_in = S_PH_CLAMP;
         S_PH_CLAMP:  state_in = S_TRUNC;
         S_TRUNC:     state_in = S_RANGE;
         S_RANGE:     if (out_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // FSM outputs: handshake, root start, multiplier operands
   always_comb begin
      req_take   = 1'b0;
      sqrt_start = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      case (state_ff)
         S_IDLE:    req_take = 1'b1;
         S_SQ_RE: begin
            mul_a = 33'(re_ff);
            mul_b = 33'(re_ff);
         end
         S_SQ_IM: begin
            mul_a = 33'(im_ff);
            mul_b = 33'(im_ff);
         end
         S_SQRT_GO: sqrt_start = 1'b1;
         S_LOG_MUL: begin
            mul_a = {1'b0, mag_ff};
            mul_b = {1'b0, mag_ff};
         end
         S_LOG_FRK: begin
            mul_a = {1'b0, fr_ff << (32 - CORDIC_STEPS)};
            mul_b = (mode_ff == MODE_DB10) ? K_DB10 : K_DB20;
         end
         S_LOG_EK: begin
            mul_a = 33'(signed'({1'b0, exp_ff})) - 33'sd16;
            mul_b = (mode_ff == MODE_DB10) ? K_DB10 : K_DB20;
         end
         default: ;
      endcase
   end

   assign req_chan.ready = req_take;

   // datapath
   logic [32:0]        sq_t;
   logic [31:0]        fl;
   logic signed [35:0] dx, dy;
   logic [51:0]        az;
   logic signed [26:0] q;
   logic signed [31:0] nmin, nmax;
   always_comb begin
      re_in = re_ff;  im_in = im_ff;  last_in_w = last_ff;
      sq_in = sq_ff;  mag_in = mag_ff; exp_in = exp_ff; fr_in = fr_ff;
      cnt_in = cnt_ff; x_in = x_ff; y_in = y_ff; z_in = z_ff;
      rem_in = rem_ff; dvs_in = dvs_ff; quot_in = quot_ff; dcnt_in = dcnt_ff;
      neg_in = neg_ff; acc_in = acc_ff; v_in = v_ff;
      run_min_in = run_min_ff; run_max_in = run_max_ff; first_in = first_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in = rsp_value_ff; rsp_min_in = rsp_min_ff;
      rsp_max_in = rsp_max_ff; rsp_last_in = rsp_last_ff;
      sq_t  = prod_ff[63:31];
      fl    = (floor_ff == 17'd0) ? 32'd1 : 32'(floor_ff);
      dx    = y_ff >>> cnt_ff;
      dy    = x_ff >>> cnt_ff;
      az    = z_ff[52] ? 52'(-z_ff) : 52'(z_ff);
      q     = neg_ff ? -27'(signed'({1'b0, quot_ff})) : 27'(signed'({1'b0, quot_ff}));
      trunc_v = (v_ff[31] && (v_ff[15:0] != 16'd0)) ?
                {v_ff[31:16], 16'd0} + 32'sh0001_0000 : {v_ff[31:16], 16'd0};
      nmin  = first_ff ? v_ff : ((v_ff < run_min_ff) ? v_ff : run_min_ff);
      nmax  = first_ff ? v_ff : ((v_ff > run_max_ff) ? v_ff : run_max_ff);
      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               re_in     = req_chan.sample_re;
               im_in     = req_chan.sample_im;
               last_in_w = req_chan.last_in;
            end
         end
         S_DISPATCH: begin
            mag_in = abs_re[31:0];
            if (is_real_fmt && (mode_ff == MODE_MOD))
               v_in = sat_hit ? 32'sh7FFF_FFFF : signed'(abs_re[31:0]);
            else if ((fmt_ff == FMT_CPLX) && (mode_ff == MODE_IM))
               v_in = im_ff;
            else
               v_in = re_ff;
         end
         S_SQ_IM:  sq_in = prod_ff[63:0];
         S_SQ_ADD: sq_in = sq_ff + prod_ff[63:0];
         S_SQRT_WAIT: begin
            mag_in = sqrt_root;
            v_in   = sqrt_root[31] ? 32'sh7FFF_FFFF : signed'(sqrt_root);
         end
         S_LOG_FLOOR: begin
            if (mag_ff < fl) mag_in = fl;
            exp_in = 5'd31;
            cnt_in = '0;
            fr_in  = '0;
         end
         S_LOG_NORM: begin
            if (!mag_ff[31]) begin
               mag_in = {mag_ff[30:0], 1'b0};
               exp_in = exp_ff - 5'd1;
            end
         end
         S_LOG_STEP: begin
            if (sq_t[32]) begin
               mag_in = sq_t[32:1];
               fr_in  = {fr_ff[30:0], 1'b1};
            end else begin
               mag_in = sq_t[31:0];
               fr_in  = {fr_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_W'(1);
         end
         S_LOG_EK:  acc_in = signed'(prod_ff[63:32]);
         S_LOG_SUM: v_in = acc_ff + signed'(prod_ff[31:0]);
         S_PH_INIT: begin
            v_in   = '0;
            cnt_in = '0;
            if (re_ff[31]) begin
               x_in = -36'(re_ff);
               y_in = -36'(im_ff);
               z_in = im_ff[31] ? -PI_Q48 : PI_Q48;
            end else begin
               x_in = 36'(re_ff);
               y_in = 36'(im_ff);
               z_in = '0;
            end
         end
         S_PH_ITER: begin
            if (y_ff != 0) begin
               if (!y_ff[35]) begin
                  x_in = x_ff + dx;
                  y_in = y_ff - dy;
                  z_in = z_ff + atan_tab[cnt_ff];
               end else begin
                  x_in = x_ff - dx;
                  y_in = y_ff + dy;
                  z_in = z_ff - atan_tab[cnt_ff];
               end
            end
            cnt_in = cnt_ff + CNT_W'(1);
         end
         S_PH_SCALE: begin
            neg_in  = z_ff[52];
            rem_in  = 60'(az) * 60'd180;
            dvs_in  = 60'(PI_Q32) << 25;
            quot_in = '0;
            dcnt_in = 5'd25;
         end
         S_PH_DIV: begin
            if (rem_ff >= dvs_ff) begin
               rem_in  = rem_ff - dvs_ff;
               quot_in = {quot_ff[24:0], 1'b1};
            end else begin
               quot_in = {quot_ff[24:0], 1'b0};
            end
            dvs_in  = dvs_ff >> 1;
            dcnt_in = dcnt_ff - 5'd1;
         end
         S_PH_CLAMP: begin
            if (q > 27'(DEG180))       v_in = DEG180;
            else if (q < -27'(DEG180)) v_in = -DEG180;
            else                       v_in = 32'(q);
         end
         S_TRUNC: if (fmt_ff == FMT_INT) v_in = trunc_v;
         S_RANGE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = last_ff;
               if (auto_ff) begin
                  run_min_in   = nmin;
                  run_max_in   = nmax;
                  first_in     = 1'b0;
                  rsp_value_in = v_ff;
                  rsp_min_in   = ph_fixed ? -DEG180 : nmin;
                  rsp_max_in   = ph_fixed ? DEG180 : nmax;
               end else begin
                  rsp_value_in = (v_ff < clip_lo_ff) ? clip_lo_ff : v_ff;
                  if (rsp_value_in > clip_hi_ff) rsp_value_in = clip_hi_ff;
                  rsp_min_in   = clip_lo_ff;
                  rsp_max_in   = clip_hi_ff;
               end
               if (last_ff) first_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      re_ff <= re_in; im_ff <= im_in; last_ff <= last_in_w;
      sq_ff <= sq_in; mag_ff <= mag_in; exp_ff <= exp_in; fr_ff <= fr_in;
      cnt_ff <= cnt_in; x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
      rem_ff <= rem_in; dvs_ff <= dvs_in; quot_ff <= quot_in; dcnt_ff <= dcnt_in;
      neg_ff <= neg_in; acc_ff <= acc_in; v_ff <= v_in;
      rsp_value_ff <= rsp_value_in; rsp_min_ff <= rsp_min_in;
      rsp_max_ff <= rsp_max_in; rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         run_min_ff   <= '0;
         run_max_ff   <= '0;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_min_ff   <= run_min_in;
         run_max_ff   <= run_max_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.value     = rsp_value_ff;
   assign rsp_chan.range_min = rsp_min_ff;
   assign rsp_chan.range_max = rsp_max_ff;
   assign rsp_chan.last_out  = rsp_last_ff;

`ifndef SYNTH
   // a transfer on the input always starts the dispatch step
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff == S_DISPATCH))
      else $error("accepted sample did not start dispatch");

   // root unit only finishes while the FSM waits for it
   a_sqrt_owner: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> (state_ff == S_SQRT_WAIT))
      else $error("square root finished outside its wait state");

   // running range stays ordered
   a_run_order: assert property (@(posedge clock) disable iff (reset)
      run_min_ff <= run_max_ff)
      else $error("running minimum above running maximum");

   // fixed phase range in auto mode
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RANGE && out_free && auto_ff && ph_fixed)
      |=> (rsp_min_ff == -DEG180 && rsp_max_ff == DEG180))
      else $error("phase range not fixed at +/-180");
`endif

endmodule

FILE: dv/tb_complex_sample_detect_and_range.sv
// Self-checking testbench for complex_sample_detect_and_range: directed and random
// samples, random handshake gaps and an internal predictor of every result.
// Depends on csdr_pkg, the csdr channel interfaces (csdr_if.sv) and the detector.
module tb_complex_sample_detect_and_range
   import csdr_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         STEPS       = CORDIC_STEPS_DEF;
   localparam logic [2:0] MODE_RE     = 3'd4;
   localparam logic [2:0] MODE_UNDEF  = 3'd6;
   localparam logic [1:0] FMT_UNKNOWN = 2'd3;
   localparam logic [2:0] REG_UNUSED  = 3'd6;
   localparam int         IDLE_LIMIT  = 4000;
   localparam int         LONG_HOLD   = 400;

   typedef struct packed {
      logic signed [31:0] value;
      logic signed [31:0] range_min;
      logic signed [31:0] range_max;
      logic               last_out;
   } detect_result_type;

   logic clock;
   logic reset;

   csdr_req_if req_bus ();
   csdr_rsp_if rsp_bus ();
   csdr_csr_if csr_bus ();

   complex_sample_detect_and_range i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // shadow registers and running range
   logic [1:0]         fmt_q;
   logic [2:0]         mode_q;
   logic               auto_q;
   logic signed [31:0] lo_q;
   logic signed [31:0] hi_q;
   logic [16:0]        floor_q;
   logic signed [31:0] run_lo;
   logic signed [31:0] run_hi;
   logic               range_restart;

   detect_result_type pending_results[$];
   int  err_count;
   int  hold_requests;
   bit  no_gaps;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- predictor ----------------

   function automatic logic [31:0] root_of(longint unsigned v);
      longint unsigned res;
      longint unsigned probe;
      res   = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
         if (v >= res + probe) begin
            v   = v - (res + probe);
            res = (res >> 1) + probe;
         end else begin
            res >>= 1;
         end
         probe >>= 2;
      end
      return res[31:0];
   endfunction

   function automatic logic signed [31:0] decibels_of(logic [31:0] m, longint k);
      logic [31:0]     fl;
      int              e;
      longint unsigned y;
      longint unsigned fr;
      longint          lg;
      longint          p;
      longint          q;
      fl = (floor_q == 0) ? 32'd1 : {15'd0, floor_q};
      if (m < fl) m = fl;
      e = 31;
      while (!m[e]) e--;
      y  = {32'd0, m} << (31 - e);
      fr = 0;
      for (int b = 0; b < STEPS; b++) begin
         y  = (y * y) >> 31;
         fr = fr << 1;
         if (y >= 64'h1_0000_0000) begin
            y  = y >> 1;
            fr = fr | 64'd1;
         end
      end
      fr = fr << (32 - STEPS);
      lg = (longint'(e) - 16) * 64'sd4294967296 + longint'(fr);
      p  = lg * k;
      q  = (p >= 0) ? (p >>> 32) : -(((-p) + 64'sh0_FFFF_FFFF) >>> 32);
      return q[31:0];
   endfunction

   // atan(2^-i), Q48 radians, from the power series in Q62
   function automatic longint arctan_step(int i);
      longint          s;
      longint unsigned t;
      int              n;
      int              pw;
      int              k;
      if (i == 0) return longint'(PI_Q60 >> 14);
      s = 0;
      k = 0;
      forever begin
         n  = 2 * k + 1;
         pw = i * n;
         if (pw > 62) break;
         t = (64'd1 << (62 - pw)) / 64'(n);
         if (k[0]) s = s - longint'(t);
         else      s = s + longint'(t);
         k++;
      end
      return (s + 8192) >>> 14;
   endfunction

   function automatic logic signed [31:0] phase_of(logic signed [31:0] re,
                                                   logic signed [31:0] im);
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      longint a;
      longint num;
      longint q;
      longint pi48;
      longint pi32;
      pi48 = longint'(PI_Q60 >> 12);
      pi32 = longint'(PI_Q60 >> 28);
      if (re == 0 && im == 0) return 32'sd0;
      x = re;
      y = im;
      z = 0;
      // left half plane: turn by 180 degrees first
      if (x < 0) begin
         x = -x;
         y = -y;
         z = (im >= 0) ? pi48 : -pi48;
      end
      for (int i = 0; i < STEPS; i++) begin
         if (y == 0) break;
         dx = y >>> i;
         dy = x >>> i;
         a  = arctan_step(i);
         if (y > 0) begin
            x = x + dx; y = y - dy; z = z + a;
         end else begin
            x = x - dx; y = y + dy; z = z - a;
         end
      end
      num = z * 180;
      q   = (num >= 0) ? num / pi32 : -((-num) / pi32);
      if (q > DEG180)  q = DEG180;
      if (q < -DEG180) q = -DEG180;
      return q[31:0];
   endfunction

   function automatic logic signed [31:0] detect_value(logic signed [31:0] re,
                                                       logic signed [31:0] im);
      longint unsigned sq;
      logic [31:0]     m;
      longint          a;
      longint          v;
      if (fmt_q == FMT_CPLX) begin
         sq = unsigned'(longint'(re) * longint'(re))
            + unsigned'(longint'(im) * longint'(im));
         case (mode_q)
            MODE_MOD: begin
               m = root_of(sq);
               return (m > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : m;
            end
            MODE_DB10:  return decibels_of(root_of(sq), K_DB10);
            MODE_DB20:  return decibels_of(root_of(sq), K_DB20);
            MODE_PHASE: return phase_of(re, im);
            MODE_IM:    return im;
            default:    return re;
         endcase
      end
      if (fmt_q == FMT_REAL || fmt_q == FMT_INT) begin
         a = (re < 0) ? -longint'(re) : longint'(re);
         if (mode_q == MODE_MOD)       v = (a > 64'sh7FFF_FFFF) ? 64'sh7FFF_FFFF : a;
         else if (mode_q == MODE_DB10) v = decibels_of(a[31:0], K_DB10);
         else if (mode_q == MODE_DB20) v = decibels_of(a[31:0], K_DB20);
         else                          v = re;
         // integer samples: drop the fraction, toward zero
         if (fmt_q == FMT_INT)
            v = (v >= 0) ? (v & ~64'shFFFF) : -((-v) & ~64'shFFFF);
         return v[31:0];
      end
      return re;
   endfunction

   function automatic detect_result_type detect_and_range(logic signed [31:0] re,
                                                          logic signed [31:0] im,
                                                          logic last);
      detect_result_type r;
      logic signed [31:0] v;
      v = detect_value(re, im);
      if (auto_q) begin
         if (range_restart) begin
            run_lo        = v;
            run_hi        = v;
            range_restart = 1'b0;
         end else begin
            if (v < run_lo) run_lo = v;
            if (v > run_hi) run_hi = v;
         end
         if (fmt_q != FMT_INT && mode_q == MODE_PHASE) begin
            r.range_min = -DEG180;
            r.range_max = DEG180;
         end else begin
            r.range_min = run_lo;
            r.range_max = run_hi;
         end
      end else begin
         if (v < lo_q) v = lo_q;
         if (v > hi_q) v = hi_q;
         r.range_min = lo_q;
         r.range_max = hi_q;
      end
      if (last) range_restart = 1'b1;
      r.value    = v;
      r.last_out = last;
      return r;
   endfunction

   // ---------------- driving ----------------

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_sample(logic signed [31:0] re, logic signed [31:0] im, logic last);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_bus.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.sample_re <= re;
      req_bus.sample_im <= im;
      req_bus.last_in   <= last;
      do @(posedge clock); while (!req_bus.ready);
      pending_results.push_back(detect_and_range(re, im, last));
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         REG_FORMAT: fmt_q   = data[1:0];
         REG_MODE:   mode_q  = data[2:0];
         REG_AUTO:   auto_q  = data[0];
         REG_CLIPLO: lo_q    = data;
         REG_CLIPHI: hi_q    = data;
         REG_FLOOR:  floor_q = data[16:0];
         default: ;
      endcase
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_detect(logic [1:0] fmt, logic [2:0] mode, logic auto_rng);
      write_reg(REG_FORMAT, 32'(fmt));
      write_reg(REG_MODE, 32'(mode));
      write_reg(REG_AUTO, 32'(auto_rng));
   endtask

   function automatic logic [31:0] rand_sample();
      case ($urandom_range(0, 5))
         0:       return $urandom_range(0, 512) - 256;
         1:       return $urandom() >>> $urandom_range(0, 31);
         2: begin
            case ($urandom_range(0, 4))
               0:       return 32'h8000_0000;
               1:       return 32'h7FFF_FFFF;
               2:       return 32'hFFFF_FFFF;
               3:       return 32'd1;
               default: return 32'd0;
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   task automatic send_random(int n, int last_odds);
      logic signed [31:0] re;
      logic signed [31:0] im;
      for (int i = 0; i < n; i++) begin
         re = rand_sample();
         im = rand_sample();
         // vectors on an axis now and then
         case ($urandom_range(0, 7))
            0:       im = 32'sd0;
            1:       re = 32'sd0;
            default: ;
         endcase
         send_sample(re, im, $urandom_range(1, last_odds) == 1);
      end
   endtask

   task automatic rand_config();
      logic [31:0] f;
      write_reg(REG_FORMAT, $urandom_range(0, 3));
      write_reg(REG_MODE, $urandom_range(0, 7));
      write_reg(REG_AUTO, $urandom());
      case ($urandom_range(0, 3))
         0: begin
            write_reg(REG_CLIPLO, 32'h8000_0000);
            write_reg(REG_CLIPHI, 32'h7FFF_FFFF);
         end
         1: begin
            write_reg(REG_CLIPLO, $urandom());
            write_reg(REG_CLIPHI, $urandom());
         end
         default: begin
            write_reg(REG_CLIPLO, -$urandom_range(0, 32'h0100_0000));
            write_reg(REG_CLIPHI, $urandom_range(0, 32'h0100_0000));
         end
      endcase
      case ($urandom_range(0, 4))
         0:       f = 32'd0;
         1:       f = 32'd65536;
         2:       f = 32'd1;
         3:       f = $urandom();
         default: f = $urandom_range(1, 65536);
      endcase
      write_reg(REG_FLOOR, f);
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom());
   endtask

   // ---------------- tests ----------------

   // modulus, decibels, phase and pass-through on edge-case samples
   task automatic test_detect_modes();
      send_sample(32'sd0, 32'sd0, 1'b0);
      send_sample(32'sh0003_0000, 32'sh0004_0000, 1'b0);
      send_sample(32'sh8000_0000, 32'sh8000_0000, 1'b1);        // modulus saturates
      drain_results();
      set_detect(FMT_CPLX, MODE_DB10, 1'b1);
      send_sample(32'sd0, 32'sd0, 1'b0);                         // floored magnitude
      send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
      drain_results();
      write_reg(REG_FLOOR, 32'd65536);
      write_reg(REG_MODE, 32'(MODE_DB20));
      send_sample(32'sh0000_1000, 32'sd0, 1'b0);
      send_sample(32'sh0100_0000, 32'sh8000_0000, 1'b1);
      drain_results();
      write_reg(REG_FLOOR, 32'd0);                               // zero floor acts as one LSB
      write_reg(REG_MODE, 32'(MODE_PHASE));
      send_sample(32'sd0, 32'sd0, 1'b0);
      send_sample(32'sh0001_0000, 32'sd0, 1'b0);                 // positive axis
      send_sample(-32'sh0001_0000, 32'sd0, 1'b0);                // negative axis
      send_sample(32'sh8000_0000, 32'sh8000_0000, 1'b0);
      send_sample(-32'sd1, 32'sh7FFF_FFFF, 1'b0);
      send_sample(32'sd0, -32'sd5, 1'b1);
      drain_results();
      set_detect(FMT_INT, MODE_PHASE, 1'b1);                     // no fixed phase range
      send_sample(-32'sh0002_8000, 32'sd7, 1'b0);
      drain_results();
      write_reg(REG_MODE, 32'(MODE_MOD));
      send_sample(32'sh8000_0000, 32'sd0, 1'b0);
      send_sample(-32'sh0005_4321, 32'sd0, 1'b1);
      drain_results();
      set_detect(FMT_REAL, MODE_IM, 1'b1);                       // imaginary mode on real samples passes re
      send_sample(32'sh1234_5678, 32'sh7FFF_FFFF, 1'b1);
      drain_results();
      set_detect(FMT_UNKNOWN, MODE_PHASE, 1'b1);
      send_sample(-32'sh0000_8000, 32'sd3, 1'b0);
      drain_results();
      write_reg(REG_MODE, 32'(MODE_UNDEF));
      send_sample(32'sh7FFF_FFFF, 32'sd0, 1'b1);
      drain_results();
      set_detect(FMT_CPLX, MODE_RE, 1'b1);
      send_sample(32'sh8000_0000, 32'sh0000_0001, 1'b1);
      drain_results();
   endtask

   // manual range, including crossed bounds
   task automatic test_manual_clip();
      set_detect(FMT_CPLX, MODE_RE, 1'b0);
      write_reg(REG_CLIPLO, -32'sh0001_0000);
      write_reg(REG_CLIPHI, 32'sh0001_0000);
      send_sample(32'sh7FFF_FFFF, 32'sd0, 1'b0);
      send_sample(32'sh8000_0000, 32'sd0, 1'b1);
      drain_results();
      write_reg(REG_CLIPLO, 32'sh0002_0000);
      write_reg(REG_CLIPHI, -32'sh0002_0000);
      send_sample(32'sd0, 32'sd0, 1'b0);
      drain_results();
      write_reg(REG_AUTO, 32'd1);                               // range restarts on last_in
      send_sample(32'sd9, 32'sd0, 1'b1);
      drain_results();
   endtask

   // random profiles under random settings
   task automatic test_random_profiles(int phases, int per_phase);
      for (int ph = 0; ph < phases; ph++) begin
         rand_config();
         no_gaps = ($urandom_range(0, 3) == 0);
         send_random(per_phase, $urandom_range(1, 12));
         drain_results();
      end
      no_gaps = 1'b0;
   endtask

   // receiver holds off long enough for the input side to stall
   task automatic test_output_stall();
      set_detect(FMT_CPLX, MODE_MOD, 1'b1);
      hold_requests++;
      no_gaps = 1'b1;
      send_random(20, 5);
      no_gaps = 1'b0;
      drain_results();
   endtask

   initial begin
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.sample_re = '0;
      req_bus.sample_im = '0;
      req_bus.last_in   = 1'b0;
      csr_bus.valid  = 1'b0;
      csr_bus.index  = '0;
      csr_bus.data   = '0;
      fmt_q          = FMT_CPLX;
      mode_q         = MODE_MOD;
      auto_q         = 1'b1;
      lo_q           = 32'sh8000_0000;
      hi_q           = 32'sh7FFF_FFFF;
      floor_q        = 17'd1;
      run_lo         = '0;
      run_hi         = '0;
      range_restart  = 1'b1;
      err_count      = 0;
      hold_requests  = 0;
      no_gaps        = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_detect_modes();
      test_manual_clip();
      test_output_stall();
      test_random_profiles(17, 25);
      test_output_stall();

      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (200) @(posedge clock);
      if (err_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // ---------------- result side ----------------

   // ready with random stalls; a long hold-off on request
   initial begin
      int seen_holds;
      int hold_left;
      int r;
      seen_holds    = 0;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (seen_holds != hold_requests) begin
            seen_holds = hold_requests;
            hold_left  = LONG_HOLD;
         end
         r = $urandom_range(0, 99);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (no_gaps || r < 70) begin
            rsp_bus.ready <= 1'b1;
         end else if (r < 97) begin
            rsp_bus.ready <= 1'b0;
         end else begin
            hold_left      = $urandom_range(10, 50);
            rsp_bus.ready <= 1'b0;
         end
      end
   end

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      detect_result_type exp_r;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result value=%h", $realtime, rsp_bus.value);
            err_count++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_bus.value !== exp_r.value) begin
               $display("%0t: value exp %h got %h", $realtime, exp_r.value, rsp_bus.value);
               err_count++;
            end
            if (rsp_bus.range_min !== exp_r.range_min) begin
               $display("%0t: range_min exp %h got %h", $realtime, exp_r.range_min,
                        rsp_bus.range_min);
               err_count++;
            end
            if (rsp_bus.range_max !== exp_r.range_max) begin
               $display("%0t: range_max exp %h got %h", $realtime, exp_r.range_max,
                        rsp_bus.range_max);
               err_count++;
            end
            if (rsp_bus.last_out !== exp_r.last_out) begin
               $display("%0t: last_out exp %b got %b", $realtime, exp_r.last_out,
                        rsp_bus.last_out);
               err_count++;
            end
         end
      end
   end

   // watchdog: cycles without any transfer
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
             || (csr_bus.valid && csr_bus.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

endmodule
